// ----- rtl/sbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned VAR_SLOTS   = 64;

  // Stack pointer holds 0..STACK_DEPTH, the address only 0..STACK_DEPTH-1.
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W  = $clog2(STACK_DEPTH);
  localparam int unsigned SU_W  = $clog2(VAR_SLOTS + 1);
  localparam int unsigned SLA_W = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_SETVAR = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_POP    = 4'd7,
    OP_CALL   = 4'd8,
    OP_HALT   = 4'd9
  } opcode_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_PRINTED   = 4'd1,
    ST_HALTED    = 4'd2,
    ST_UNDEF     = 4'd3,
    ST_DIVZERO   = 4'd4,
    ST_UNKFUNC   = 4'd5,
    ST_UNDERFLOW = 4'd6,
    ST_OVERFLOW  = 4'd7,
    ST_IGNORED   = 4'd8
  } status_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_OPA    = 8'b0000_0100,
    S_ALU    = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_SEARCH = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stack-machine executor: each input request is one instruction (tuser carries the
// opcode) and produces exactly one result (tuser carries the status, tdata the printed
// value). A request is taken only when the sequencer is idle and the output register is
// empty, so one instruction is in flight at a time. After acceptance, push, pop, halt, an
// ignored request and every error found at decode go from decode straight to done; a print
// call passes through commit, and a division by zero ends in the ALU state; add, sub and mul
// go through operand fetch, ALU and commit, bound by two registered reads of the single stack
// read port; div adds a divide loop before commit, the shared adder doing one restoring
// quotient bit per cycle; load and store, and an undefined variable, scan the key table one
// slot per cycle through its one read port, over the variable slots in use.
// After a halt or any error every request answers "ignored" until reset.
module stack_bytecode_executor
  import sbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,     // print_function_key
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [31:0] immediate, [63:32] name_key
  input  wire logic [3:0]  s_axis_tuser_i,  // [3:0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [31:0] printed_value
  output logic [3:0]       m_axis_tuser_o   // [3:0] status
);

  state_e              state_q, state_d;
  logic [3:0]          mode_q;
  logic [DATA_W-1:0]   imm_q, key_q, pfk_q;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [SU_W-1:0]     used_q, used_d;
  logic                stopped_q, stopped_d;
  status_e             st_q, st_d;
  logic [DATA_W-1:0]   prn_q, prn_d;
  logic [DATA_W-1:0]   b_q, b_d;
  logic [DATA_W-1:0]   res_q, res_d;
  logic [DATA_W-1:0]   dvd_q, dvd_d, dvs_q, dvs_d;
  logic [DATA_W-2:0]   rem_q, rem_d;
  logic                neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SU_W-1:0]     scan_q, scan_d;
  logic                cmp_v_q, cmp_v_d;
  logic [SLA_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_st_q;
  logic [DATA_W-1:0]   out_val_q;

  // Value stack memory.
  logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
  logic                stk_re, stk_we;
  logic [SA_W-1:0]     stk_raddr, stk_waddr;
  logic [DATA_W-1:0]   stk_wdata, stk_rd_q;

  // Variable table memories, read at one shared address.
  logic [DATA_W-1:0]   key_mem [VAR_SLOTS];
  logic [DATA_W-1:0]   val_mem [VAR_SLOTS];
  logic                slot_re, key_we, val_we;
  logic [SLA_W-1:0]    slot_raddr, slot_waddr;
  logic [DATA_W-1:0]   val_wdata;
  logic [DATA_W-1:0]   key_rd_q, val_rd_q;

  // Shared adder: add, sub and the divider trial subtraction.
  logic [DATA_W-1:0]   add_x, add_y;
  logic                add_sub;
  logic [DATA_W:0]     add_sum;
  logic [2*DATA_W-1:0] mul_full;
  logic                accept;
  logic                qbit;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_st_q;

  always_comb begin
    if (state_q == S_DIV) begin
      add_x   = {rem_q, dvd_q[DATA_W-1]};
      add_y   = dvs_q;
      add_sub = 1'b1;
    end else begin
      add_x   = stk_rd_q;
      add_y   = b_q;
      add_sub = (mode_q == OP_SUB);
    end
    add_sum  = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {{DATA_W{1'b0}}, add_sub};
    mul_full = stk_rd_q * b_q;
  end

  // Carry out of the trial subtraction means the divisor fits.
  assign qbit = add_sum[DATA_W];

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    used_d      = used_q;
    stopped_d   = stopped_q;
    st_d        = st_q;
    prn_d       = prn_q;
    b_d         = b_q;
    res_d       = res_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q;

    stk_re     = 1'b0;
    stk_raddr  = SA_W'(sp_q - SP_W'(1));
    stk_we     = 1'b0;
    stk_waddr  = sp_q[SA_W-1:0];
    stk_wdata  = imm_q;
    slot_re    = 1'b0;
    slot_raddr = scan_q[SLA_W-1:0];
    key_we     = 1'b0;
    val_we     = 1'b0;
    slot_waddr = cmp_idx_q;
    val_wdata  = stk_rd_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          prn_d   = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        stk_re  = 1'b1;
        state_d = S_DONE;
        scan_d  = '0;
        cmp_v_d = 1'b0;
        if (stopped_q) begin
          st_d = ST_IGNORED;
        end else begin
          case (mode_q)
            OP_PUSH: begin
              if (sp_q == SP_W'(STACK_DEPTH)) begin
                st_d = ST_OVERFLOW;
              end else begin
                stk_we = 1'b1;
                sp_d   = sp_q + SP_W'(1);
              end
            end
            OP_LOAD: begin
              if (sp_q == SP_W'(STACK_DEPTH)) begin
                st_d = ST_OVERFLOW;
              end else begin
                state_d = S_SEARCH;
              end
            end
            OP_SETVAR: begin
              if (sp_q == '0) begin
                st_d = ST_UNDERFLOW;
              end else begin
                state_d = S_SEARCH;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp_q < SP_W'(2)) begin
                st_d = ST_UNDERFLOW;
              end else begin
                state_d = S_OPA;
              end
            end
            OP_POP: begin
              if (sp_q == '0) begin
                st_d = ST_UNDERFLOW;
              end else begin
                sp_d = sp_q - SP_W'(1);
              end
            end
            OP_CALL: begin
              if (key_q != pfk_q) begin
                st_d = ST_UNKFUNC;
              end else if (sp_q == '0) begin
                st_d = ST_UNDERFLOW;
              end else begin
                state_d = S_COMMIT;
              end
            end
            OP_HALT: begin
              st_d = ST_HALTED;
            end
            default: begin
              st_d = ST_IGNORED;
            end
          endcase
        end
      end
      S_OPA: begin
        // Top of stack has arrived; fetch the operand below it.
        b_d       = stk_rd_q;
        stk_re    = 1'b1;
        stk_raddr = SA_W'(sp_q - SP_W'(2));
        state_d   = S_ALU;
      end
      S_ALU: begin
        state_d = S_COMMIT;
        case (mode_q)
          OP_ADD, OP_SUB: res_d = add_sum[DATA_W-1:0];
          OP_MUL:         res_d = mul_full[DATA_W-1:0];
          default: begin
            if (b_q == '0) begin
              st_d    = ST_DIVZERO;
              state_d = S_DONE;
            end else begin
              neg_d   = stk_rd_q[DATA_W-1] ^ b_q[DATA_W-1];
              dvd_d   = stk_rd_q[DATA_W-1] ? (~stk_rd_q + DATA_W'(1)) : stk_rd_q;
              dvs_d   = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;
              rem_d   = '0;
              cnt_d   = '0;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        rem_d = qbit ? add_sum[DATA_W-2:0] : add_x[DATA_W-2:0];
        dvd_d = {dvd_q[DATA_W-2:0], qbit};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
          res_d   = neg_q ? (~{dvd_q[DATA_W-2:0], qbit} + DATA_W'(1))
                          : {dvd_q[DATA_W-2:0], qbit};
          state_d = S_COMMIT;
        end
      end
      S_SEARCH: begin
        // One slot read is issued per cycle; its key is compared in the next one.
        if (cmp_v_q && key_rd_q == key_q) begin
          state_d = S_DONE;
          if (mode_q == OP_LOAD) begin
            stk_we    = 1'b1;
            stk_wdata = val_rd_q;
            sp_d      = sp_q + SP_W'(1);
          end else begin
            val_we = 1'b1;
            sp_d   = sp_q - SP_W'(1);
          end
        end else if (scan_q < used_q) begin
          slot_re   = 1'b1;
          scan_d    = scan_q + SU_W'(1);
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_q[SLA_W-1:0];
        end else begin
          state_d = S_DONE;
          if (mode_q == OP_LOAD) begin
            st_d = ST_UNDEF;
          end else begin
            sp_d = sp_q - SP_W'(1);
            if (used_q < SU_W'(VAR_SLOTS)) begin
              key_we     = 1'b1;
              val_we     = 1'b1;
              slot_waddr = used_q[SLA_W-1:0];
              used_d     = used_q + SU_W'(1);
            end
          end
        end
      end
      S_COMMIT: begin
        state_d = S_DONE;
        if (mode_q == OP_CALL) begin
          prn_d = stk_rd_q;
          st_d  = ST_PRINTED;
          sp_d  = sp_q - SP_W'(1);
        end else begin
          stk_we    = 1'b1;
          stk_waddr = SA_W'(sp_q - SP_W'(2));
          stk_wdata = res_q;
          sp_d      = sp_q - SP_W'(1);
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (st_q inside {ST_HALTED, [ST_UNDEF:ST_OVERFLOW]}) begin
          stopped_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      used_q      <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pfk_q       <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      used_q      <= used_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      cmp_v_q     <= cmp_v_d;
      if (cfg_we_i) begin
        pfk_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser_i;
      imm_q  <= s_axis_tdata_i[31:0];
      key_q  <= s_axis_tdata_i[63:32];
    end
    st_q      <= st_d;
    prn_q     <= prn_d;
    b_q       <= b_d;
    res_q     <= res_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    cmp_idx_q <= cmp_idx_d;
    if (state_q == S_DONE) begin
      out_st_q  <= st_q;
      out_val_q <= prn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[slot_waddr] <= key_q;
    end
    if (slot_re) begin
      key_rd_q <= key_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[slot_waddr] <= val_wdata;
    end
    if (slot_re) begin
      val_rd_q <= val_mem[slot_raddr];
    end
  end

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && out_valid_q))
    else $error("request accepted while a result is pending");

  a_sp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SU_W'(VAR_SLOTS))
    else $error("slot count beyond table size");

  a_stopped_ignores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && stopped_q) |-> (st_q == ST_IGNORED))
    else $error("stopped block produced a status other than ignored");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule

`default_nettype wire
